// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_PROP_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_PROP_NR(label, clk, prop)
`endif

`endif

// ===== rtl/core/qph_pkg.sv =====
package qph_pkg;

  localparam int HASH_W   = 32;
  localparam int LEN_W    = 4;
  localparam int MOD_STEP = 8;
  localparam int MOD_CYC  = HASH_W / MOD_STEP;
  localparam int MCNT_W   = 2;
  localparam int COUNT_W  = 7;
  localparam int SLOT_W   = 7;
  localparam int VOUT_W   = 32;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd50;

  typedef enum logic [1:0] {
    FN_INSERT,
    FN_DELETE,
    FN_LOOKUP,
    FN_CLEAR
  } func_t;

  typedef enum logic [1:0] {
    ST_EMPTY,
    ST_ACTIVE,
    ST_DELETED
  } slot_st_t;

  typedef enum logic [1:0] {
    RS_DONE,
    RS_NOOP,
    RS_NOT_FOUND,
    RS_LIMIT
  } res_status_t;

endpackage

// ===== rtl/core/qph_hash.sv =====
module qph_hash
  import qph_pkg::*;
#(
  parameter int TABLE_SIZE = 101,
  parameter int KEY_BYTES  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [KEY_BYTES-1:0][7:0]     key,
  input  logic [LEN_W-1:0]              len,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] home
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int BW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  typedef enum logic [1:0] {
    H_IDLE,
    H_BYTES,
    H_MOD
  } hstate_t;

  hstate_t                   hs;
  logic [KEY_BYTES-1:0][7:0] key_r;
  logic [LEN_W-1:0]          rem;
  logic [HASH_W-1:0]         h;
  logic [MCNT_W-1:0]         mcnt;
  logic [IW-1:0]             r;

  logic [BW-1:0]     byte_idx;
  logic [HASH_W-1:0] byte_ext;
  logic [HASH_W-1:0] h_next;
  logic [IW-1:0]     r_next;
  logic [HASH_W-1:0] h_shift;

  assign byte_idx = BW'(rem - 1'b1);
  assign byte_ext = {{(HASH_W-8){key_r[byte_idx][7]}}, key_r[byte_idx]};
  assign h_next   = (h << 5) ^ byte_ext ^ h;
  assign h_shift  = h << MOD_STEP;

  always_comb begin
    logic [IW:0]       t;
    logic [HASH_W-1:0] hv;
    r_next = r;
    hv     = h;
    for (int i = 0; i < MOD_STEP; i++) begin
      t = {r_next, hv[HASH_W-1]};
      if (t >= (IW+1)'(TABLE_SIZE)) begin
        t = t - (IW+1)'(TABLE_SIZE);
      end
      r_next = t[IW-1:0];
      hv     = hv << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hs   <= H_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (hs)
        H_IDLE: begin
          if (start) begin
            key_r <= key;
            rem   <= len;
            h     <= '0;
            r     <= '0;
            mcnt  <= '0;
            hs    <= (len != '0) ? H_BYTES : H_MOD;
          end
        end
        H_BYTES: begin
          h   <= h_next;
          rem <= rem - 1'b1;
          if (rem == LEN_W'(1)) begin
            hs <= H_MOD;
          end
        end
        H_MOD: begin
          r    <= r_next;
          h    <= h_shift;
          mcnt <= mcnt + 1'b1;
          if (mcnt == MCNT_W'(MOD_CYC - 1)) begin
            home <= r_next;
            done <= 1'b1;
            hs   <= H_IDLE;
          end
        end
        default: hs <= H_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/quadratic_probe_hash_table.sv =====
// Open-addressing hash map with quadratic probing and lazy deletion. Each input
// beat is one operation (insert, delete, lookup, clear) and yields exactly one
// output beat. All slot state sits in one single-port-read, single-port-write
// memory of TABLE_SIZE words with a registered read; the home slot comes from a
// shift-xor hash worked one key byte per cycle, then reduced modulo TABLE_SIZE
// eight bits per cycle. An insert, delete or lookup hashes the key, then spends
// one read state and one compare state on each probe. A clear, and the pass
// after reset, sweep the memory one slot per cycle; no input beat is taken
// during the sweep (occupancy_limit writes still land). The block works on one
// beat at a time; a finished result waits in the output register while the next
// beat is taken.
`include "assert_macros.svh"

module quadratic_probe_hash_table
  import qph_pkg::*;
#(
  parameter int TABLE_SIZE = 101,
  parameter int KEY_BYTES  = 8,
  parameter int VALUE_BITS = 32,
  parameter int MAX_PROBES = 51
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [6:0]   cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_bytes[63:0], key_length[67:64], value_in[99:68], zero pad
  input  logic [103:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found[0], value_out[32:1], status[34:33], over_threshold[35],
  // slot_index[42:36], zero pad
  output logic [47:0]  m_axis_tdata
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int NW = $clog2(MAX_PROBES + 1);
  localparam int KW = 8 * KEY_BYTES;

  typedef struct packed {
    slot_st_t              st;
    logic [LEN_W-1:0]      len;
    logic [KW-1:0]         key;
    logic [VALUE_BITS-1:0] val;
  } slot_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_RESP
  } state_t;

  state_t                  state;
  logic                    sweep_clear;
  logic [IW-1:0]           sweep_addr;
  func_t                   func_r;
  logic [KW-1:0]           key_r;
  logic [LEN_W-1:0]        len_r;
  logic [VALUE_BITS-1:0]   val_r;
  logic [IW-1:0]           pos_r;
  logic [IW-1:0]           inc_r;
  logic [NW-1:0]           n_r;
  logic [COUNT_W-1:0]      count_r;
  logic [COUNT_W-1:0]      limit_r;
  logic                    res_found;
  logic [VOUT_W-1:0]       res_value;
  res_status_t             res_status;
  logic [IW-1:0]           res_slot;

  slot_t                   mem [TABLE_SIZE];
  slot_t                   rd;
  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  slot_t                   mem_wdata;

  logic                    in_beat;
  func_t                   in_func;
  logic [LEN_W-1:0]        in_len;
  logic [LEN_W-1:0]        len_c;
  logic [KEY_BYTES-1:0][7:0] key_m;
  logic                    hash_start;
  logic                    hash_done;
  logic [IW-1:0]           hash_home;

  logic                    hit;
  logic                    active;
  logic                    last_probe;
  logic [IW:0]             pos_sum;
  logic [IW:0]             inc_sum;
  logic [IW-1:0]           pos_next;
  logic [IW-1:0]           inc_next;
  logic                    over;

  assign s_axis_tready = (state == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign in_func       = func_t'(s_axis_tuser);
  assign in_len        = s_axis_tdata[67:64];
  assign len_c         = (in_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : in_len;

  always_comb begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      key_m[i] = (LEN_W'(i) < len_c) ? s_axis_tdata[8*i +: 8] : 8'h00;
    end
  end

  assign hash_start = in_beat && (in_func != FN_CLEAR);

  qph_hash #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_BYTES  (KEY_BYTES)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key_m),
    .len   (len_c),
    .done  (hash_done),
    .home  (hash_home)
  );

  assign hit        = (rd.st == ST_EMPTY) || ((rd.key == key_r) && (rd.len == len_r));
  assign active     = (rd.st == ST_ACTIVE);
  assign last_probe = ((n_r + 1'b1) >= NW'(MAX_PROBES));
  assign pos_sum    = {1'b0, pos_r} + {1'b0, inc_r};
  assign inc_sum    = {1'b0, inc_r} + (IW+1)'(2);
  assign pos_next   = (pos_sum >= (IW+1)'(TABLE_SIZE)) ?
                      IW'(pos_sum - (IW+1)'(TABLE_SIZE)) : IW'(pos_sum);
  assign inc_next   = (inc_sum >= (IW+1)'(TABLE_SIZE)) ?
                      IW'(inc_sum - (IW+1)'(TABLE_SIZE)) : IW'(inc_sum);
  assign over       = (count_r > limit_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = '0;
    if (state == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
    end else if (state == S_CHECK && hit) begin
      if (func_r == FN_INSERT && !active) begin
        mem_we    = 1'b1;
        mem_wdata = '{st: ST_ACTIVE, len: len_r, key: key_r, val: val_r};
      end else if (func_r == FN_DELETE && active) begin
        mem_we    = 1'b1;
        mem_wdata = '{st: ST_DELETED, len: rd.len, key: rd.key, val: rd.val};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_READ) begin
      rd <= mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SWEEP;
      sweep_clear   <= 1'b0;
      sweep_addr    <= '0;
      count_r       <= '0;
      limit_r       <= LIMIT_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        limit_r <= cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready && state != S_RESP) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func_r <= in_func;
            key_r  <= KW'(key_m);
            len_r  <= len_c;
            val_r  <= VALUE_BITS'(s_axis_tdata[99:68]);
            if (in_func == FN_CLEAR) begin
              sweep_addr  <= '0;
              sweep_clear <= 1'b1;
              state       <= S_SWEEP;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == IW'(TABLE_SIZE - 1)) begin
            if (sweep_clear) begin
              count_r    <= '0;
              res_found  <= 1'b0;
              res_value  <= '0;
              res_status <= RS_DONE;
              res_slot   <= '0;
              state      <= S_RESP;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            pos_r <= hash_home;
            inc_r <= IW'(1);
            n_r   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (hit) begin
            res_found <= active;
            res_slot  <= pos_r;
            res_value <= '0;
            state     <= S_RESP;
            case (func_r)
              FN_INSERT: begin
                if (active) begin
                  res_status <= RS_NOOP;
                end else begin
                  res_status <= RS_DONE;
                  if (count_r != '1) begin
                    count_r <= count_r + 1'b1;
                  end
                end
              end
              FN_DELETE: begin
                res_status <= active ? RS_DONE : RS_NOOP;
              end
              default: begin
                if (active) begin
                  res_status <= RS_DONE;
                  res_value  <= VOUT_W'(rd.val);
                end else begin
                  res_status <= RS_NOT_FOUND;
                end
              end
            endcase
          end else if (last_probe) begin
            res_found  <= 1'b0;
            res_value  <= '0;
            res_status <= RS_LIMIT;
            res_slot   <= pos_r;
            state      <= S_RESP;
          end else begin
            pos_r <= pos_next;
            inc_r <= inc_next;
            n_r   <= n_r + 1'b1;
            state <= S_READ;
          end
        end
        S_RESP: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {5'b0, SLOT_W'(res_slot), over, res_status,
                              res_value, res_found};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_PROP_NR(a_rst_blocks_input, clk, rst |=> !s_axis_tready)
  `ASSERT_PROP(a_check_after_read, clk, rst, (state == S_CHECK) |-> ($past(state) == S_READ))
  `ASSERT_PROP(a_pos_in_table, clk, rst, (state == S_READ) |-> (pos_r < IW'(TABLE_SIZE)))
  `ASSERT_PROP(a_probe_bound, clk, rst, (state == S_CHECK) |-> (n_r < NW'(MAX_PROBES)))
  `ASSERT_PROP(a_count_drops_on_clear, clk, rst, (count_r < $past(count_r)) |-> ($past(state) == S_SWEEP))

endmodule

// ===== sim/tb_quadratic_probe_hash_table.sv =====
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_table;
  import qph_pkg::*;

  localparam int SLOTS = 101;
  localparam int PROBE_CAP = 51;
  localparam int COUNT_SAT = 127;
  localparam int POOL_SIZE = 48;
  localparam int PHASE_ITEMS = 232;
  localparam int REPORT_MAX = 10;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES = 150;
  localparam int DIR_ROWS = 21;

  typedef enum int {
    MIX_GENERAL,
    MIX_FILL,
    MIX_CHURN
  } op_mix_t;

  typedef struct packed {
    logic        found;
    logic [31:0] value;
    res_status_t status;
    logic        over;
    logic [6:0]  slot;
  } hash_result_t;

  typedef struct packed {
    func_t        op;
    logic [63:0]  key;
    logic [3:0]   len;
    logic [31:0]  val;
    logic         typed;
    hash_result_t want;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{FN_LOOKUP, 64'h0, 4'd0, 32'h0, 1'b1, '{1'b0, 32'h0, RS_NOT_FOUND, 1'b0, 7'd0}},
    '{FN_INSERT, 64'h0, 4'd0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, RS_DONE, 1'b0, 7'd0}},
    '{FN_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'h0, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, RS_DONE, 1'b0, 7'd0}},
    '{FN_INSERT, 64'h0, 4'd0, 32'h1234_5678, 1'b1, '{1'b1, 32'h0, RS_NOOP, 1'b0, 7'd0}},
    '{FN_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0, 1'b0, '0},
    '{FN_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h1, 1'b0, '0},
    '{FN_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 32'h0, 1'b0, '0},
    '{FN_INSERT, 64'hA5A5_0000_0000_0041, 4'd1, 32'h11, 1'b0, '0},
    '{FN_LOOKUP, 64'h0000_0000_0000_0041, 4'd2, 32'h0, 1'b0, '0},
    '{FN_INSERT, 64'h0000_0000_0000_0041, 4'd2, 32'h22, 1'b0, '0},
    '{FN_DELETE, 64'h0000_0000_0000_0041, 4'd1, 32'h0, 1'b0, '0},
    '{FN_DELETE, 64'h0000_0000_0000_0041, 4'd1, 32'h0, 1'b0, '0},
    '{FN_LOOKUP, 64'h0000_0000_0000_0041, 4'd1, 32'h0, 1'b0, '0},
    '{FN_INSERT, 64'h0000_0000_0000_0041, 4'd1, 32'h33, 1'b0, '0},
    '{FN_LOOKUP, 64'h0000_0000_0000_0041, 4'd1, 32'h0, 1'b0, '0},
    '{FN_INSERT, 64'h0000_0000_0000_0080, 4'd1, 32'h8000_0000, 1'b0, '0},
    '{FN_LOOKUP, 64'h0000_0000_0000_FF80, 4'd1, 32'h0, 1'b0, '0},
    '{FN_DELETE, 64'h0000_0000_0000_1234, 4'd2, 32'h0, 1'b0, '0},
    '{FN_CLEAR, 64'h5555_AAAA_5555_AAAA, 4'd7, 32'hDEAD_BEEF, 1'b1,
      '{1'b0, 32'h0, RS_DONE, 1'b0, 7'd0}},
    '{FN_LOOKUP, 64'h0, 4'd0, 32'h0, 1'b1, '{1'b0, 32'h0, RS_NOT_FOUND, 1'b0, 7'd0}},
    '{FN_LOOKUP, 64'h0000_0000_0000_0041, 4'd1, 32'h0, 1'b0, '0}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wen = 1'b0;
  logic [6:0]   cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;

  int sender_idle_pct = 0;
  int rx_stall_pct = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  hash_result_t pending_results[$];

  slot_st_t    mirror_state [SLOTS];
  logic [63:0] mirror_key [SLOTS];
  logic [3:0]  mirror_len [SLOTS];
  logic [31:0] mirror_val [SLOTS];
  int          mirror_count;
  logic [6:0]  mirror_limit;

  logic [63:0] pool_keys [POOL_SIZE];
  logic [3:0]  pool_lens [POOL_SIZE];

  quadratic_probe_hash_table DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] key_mask(int unsigned n_bytes);
    return (n_bytes == 0) ? 64'd0 : ({64{1'b1}} >> (64 - 8 * n_bytes));
  endfunction

  function automatic logic [31:0] shift_xor_hash(logic [63:0] k, int unsigned n_bytes);
    logic [31:0] h;
    logic [7:0]  c;
    int unsigned i;
    h = '0;
    for (i = 0; i < n_bytes; i++) begin
      c = k[8 * (n_bytes - 1 - i) +: 8];
      h = (h << 5) ^ {{24{c[7]}}, c} ^ h;
    end
    return h;
  endfunction

  function automatic hash_result_t hash_table_step(func_t op, logic [63:0] raw_key,
                                                   logic [3:0] raw_len, logic [31:0] val);
    hash_result_t r;
    int unsigned  n_bytes;
    logic [63:0]  k;
    int unsigned  p;
    int unsigned  n;
    int unsigned  i;
    logic         hit;
    logic         active;
    r = '0;
    n_bytes = (raw_len > 8) ? 8 : raw_len;
    k = raw_key & key_mask(n_bytes);
    if (op == FN_CLEAR) begin
      for (i = 0; i < SLOTS; i++) mirror_state[i] = ST_EMPTY;
      mirror_count = 0;
    end else begin
      p = shift_xor_hash(k, n_bytes) % SLOTS;
      hit = 1'b0;
      for (n = 0; n < PROBE_CAP && !hit; n++) begin
        if (mirror_state[p] == ST_EMPTY || (mirror_key[p] == k && mirror_len[p] == n_bytes))
          hit = 1'b1;
        else if (n + 1 < PROBE_CAP)
          p = (p + 2 * (n + 1) - 1) % SLOTS;
      end
      r.slot = p[6:0];
      if (!hit) begin
        r.status = RS_LIMIT;
      end else begin
        active = (mirror_state[p] == ST_ACTIVE);
        r.found = active;
        case (op)
          FN_INSERT: begin
            if (active) begin
              r.status = RS_NOOP;
            end else begin
              mirror_state[p] = ST_ACTIVE;
              mirror_key[p] = k;
              mirror_len[p] = n_bytes[3:0];
              mirror_val[p] = val;
              if (mirror_count < COUNT_SAT) mirror_count++;
            end
          end
          FN_DELETE: begin
            if (active) mirror_state[p] = ST_DELETED;
            else r.status = RS_NOOP;
          end
          default: begin
            if (active) r.value = mirror_val[p];
            else r.status = RS_NOT_FOUND;
          end
        endcase
      end
    end
    r.over = (mirror_count > mirror_limit);
    return r;
  endfunction

  // hold the beat until accepted, then queue what it should produce
  task automatic send_op(func_t op, logic [63:0] key, logic [3:0] len, logic [31:0] val,
                         logic typed, hash_result_t want);
    hash_result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, val, len, key};
    s_axis_tuser <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = hash_table_step(op, key, len, val);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic write_limit(logic [6:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    mirror_limit = v;
  endtask

  task automatic draw_pool_key(output logic [63:0] k, output logic [3:0] n);
    int idx;
    idx = $urandom_range(POOL_SIZE - 1);
    n = pool_lens[idx];
    k = pool_keys[idx] | ({$urandom, $urandom} & ~key_mask(n));
    if (n == 8 && $urandom_range(1) == 1) n = 4'($urandom_range(15, 8));
  endtask

  task automatic run_phase(op_mix_t mix, int items);
    func_t       op;
    logic [63:0] k;
    logic [3:0]  n;
    logic        use_pool;
    int          r;
    int          i;
    for (i = 0; i < items; i++) begin
      r = $urandom_range(99);
      case (mix)
        MIX_FILL: begin
          op = (r < 70) ? FN_INSERT : (r < 80) ? FN_DELETE : FN_LOOKUP;
          use_pool = (op != FN_INSERT) && ($urandom_range(1) == 1);
        end
        MIX_CHURN: begin
          op = (r < 45) ? FN_INSERT : (r < 80) ? FN_DELETE : FN_LOOKUP;
          use_pool = ($urandom_range(9) != 0);
        end
        default: begin
          op = (r < 3) ? FN_CLEAR : (r < 40) ? FN_INSERT : (r < 60) ? FN_DELETE : FN_LOOKUP;
          use_pool = ($urandom_range(3) != 0);
        end
      endcase
      if (use_pool) begin
        draw_pool_key(k, n);
      end else begin
        k = {$urandom, $urandom};
        n = 4'($urandom_range(15));
      end
      send_op(op, k, n, $urandom, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin : result_check
    hash_result_t got;
    hash_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.found = m_axis_tdata[0];
      got.value = m_axis_tdata[32:1];
      got.status = res_status_t'(m_axis_tdata[34:33]);
      got.over = m_axis_tdata[35];
      got.slot = m_axis_tdata[42:36];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found || got.value !== want.value ||
            got.status !== want.status || got.over !== want.over ||
            got.slot !== want.slot) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch found/value/status/over/slot: exp %0d %h %0d %0d %0d, got %0d %h %0d %0d %0d",
                     want.found, want.value, want.status, want.over, want.slot,
                     got.found, got.value, got.status, got.over, got.slot);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    for (i = 0; i < SLOTS; i++) begin
      mirror_state[i] = ST_EMPTY;
      mirror_key[i] = '0;
      mirror_len[i] = '0;
      mirror_val[i] = '0;
    end
    mirror_count = 0;
    mirror_limit = LIMIT_RESET;
    for (i = 0; i < POOL_SIZE; i++) begin
      pool_lens[i] = 4'($urandom_range(8));
      pool_keys[i] = {$urandom, $urandom} & key_mask(pool_lens[i]);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++)
      send_op(DIR_TABLE[i].op, DIR_TABLE[i].key, DIR_TABLE[i].len, DIR_TABLE[i].val,
              DIR_TABLE[i].typed, DIR_TABLE[i].want);

    write_limit(7'd0);
    run_phase(MIX_GENERAL, PHASE_ITEMS);

    write_limit(7'd101);
    sender_idle_pct = 52;
    run_phase(MIX_FILL, PHASE_ITEMS);

    write_limit(7'd127);
    sender_idle_pct = 0;
    rx_stall_pct = 52;
    run_phase(MIX_CHURN, PHASE_ITEMS);

    write_limit(7'($urandom_range(100, 1)));
    sender_idle_pct = 12;
    rx_stall_pct = 12;
    run_phase(MIX_GENERAL, PHASE_ITEMS);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
